// ----- rtl/core/bct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants of the body command table: record layout,
// command codes, flag bits, register indexes and reset values.
// ----------------------------------------------------------------------------
package bct_pkg;

    localparam int NUM_BODIES_DEF = 1024;

    localparam int WORD_W  = 32;
    localparam int NUM_WORDS = 12;
    localparam int FLAGS_W = 3;
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 10;

    // command codes
    localparam logic [CMD_W-1:0] CMD_DESTROY    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SPAWN      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CORRECTION = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_VEL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IMPULSE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_AWAKE  = 3'd5;

    // flag bit positions
    localparam int FLAG_ALIVE  = 0;
    localparam int FLAG_AWAKE  = 1;
    localparam int FLAG_STATIC = 2;

    localparam logic [WORD_W-1:0] GEN_MAX = 32'hFFFF_FFFF;

    // configuration registers
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 31;
    localparam logic [CFG_ADDR_W-1:0] CFG_BODY_COUNT  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECTOR_HALF = 1'd1;
    localparam int BODY_COUNT_W  = 11;
    localparam int SECTOR_HALF_W = 31;
    localparam logic [BODY_COUNT_W-1:0]  BODY_COUNT_RST  = 11'd1024;
    localparam logic [SECTOR_HALF_W-1:0] SECTOR_HALF_RST = 31'h4000_0000;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] words_t;

    // one body slot
    typedef struct packed {
        logic [WORD_W-1:0]  generation;
        logic [FLAGS_W-1:0] flags;
        logic [WORD_W-1:0]  sector_x;
        logic [WORD_W-1:0]  sector_y;
        logic [WORD_W-1:0]  sector_z;
        logic [WORD_W-1:0]  radius;
        logic [WORD_W-1:0]  position_x;
        logic [WORD_W-1:0]  position_y;
        logic [WORD_W-1:0]  position_z;
        logic [WORD_W-1:0]  inv_mass;
        logic [WORD_W-1:0]  velocity_x;
        logic [WORD_W-1:0]  velocity_y;
        logic [WORD_W-1:0]  velocity_z;
    } body_rec_t;

    // signed saturating add of two 32-bit words
    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] s;
        s = a + b;
        if ((a[WORD_W-1] == b[WORD_W-1]) && (s[WORD_W-1] != a[WORD_W-1])) begin
            s = a[WORD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        return s;
    endfunction

    // -half <= p < half, p signed, half unsigned
    function automatic logic in_sector(input logic [WORD_W-1:0] p,
                                       input logic [SECTOR_HALF_W-1:0] half);
        logic signed [WORD_W:0] ps;
        logic signed [WORD_W:0] hs;
        ps = $signed({p[WORD_W-1], p});
        hs = $signed({2'b00, half});
        return (ps >= -hs) && (ps < hs);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/body_command_table_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// body_command_table_unit
// Table of rigid-body records with generation-checked commands.
// ----------------------------------------------------------------------------
// Each beat on the input stream is one command on one body slot; each
// command returns exactly one result beat (accept flag, slot generation and
// slot flags after the command). The slot record is read from the record
// memory when the command is taken, then updated and written back once the
// result register is free to take the result; the next command is taken only
// after that, so a new command is never taken while one is in flight. After
// reset the unit clears the record memory, one slot per cycle, before s_tready
// rises; configuration writes are taken at all times and must only be
// issued while no command is in flight.
// ----------------------------------------------------------------------------
module body_command_table_unit #(
    parameter int NUM_BODIES = bct_pkg::NUM_BODIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [bct_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [bct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // command stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // command, body_index, generation, payload_01, payload_23, payload_45,
    // payload_67, payload_89, payload_ab, zero pad
    input  wire logic [431:0]                      s_tdata,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // accepted, slot_generation, slot_flags, zero pad
    output logic [39:0]                            m_tdata
);

    localparam int ADDR_W = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;

    // input field unpacking
    logic [bct_pkg::CMD_W-1:0]   in_command;
    logic [bct_pkg::INDEX_W-1:0] in_index;
    logic [bct_pkg::WORD_W-1:0]  in_generation;
    bct_pkg::words_t             in_words;

    assign in_command    = s_tdata[2:0];
    assign in_index      = s_tdata[12:3];
    assign in_generation = s_tdata[44:13];
    assign in_words      = s_tdata[428:45];

    // configuration registers
    logic [bct_pkg::BODY_COUNT_W-1:0]  body_count_reg;
    logic [bct_pkg::SECTOR_HALF_W-1:0] sector_half_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_count_reg  <= bct_pkg::BODY_COUNT_RST;
            sector_half_reg <= bct_pkg::SECTOR_HALF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bct_pkg::CFG_BODY_COUNT:
                    body_count_reg <= cfg_wdata[bct_pkg::BODY_COUNT_W-1:0];
                bct_pkg::CFG_SECTOR_HALF:
                    sector_half_reg <= cfg_wdata[bct_pkg::SECTOR_HALF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clearing pass after reset
    logic              clear_reg;
    logic              clear_next;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic [ADDR_W-1:0] clear_cnt_next;

    always_comb begin
        clear_next     = clear_reg;
        clear_cnt_next = clear_cnt_reg;
        if (clear_reg) begin
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == ADDR_W'(NUM_BODIES - 1)) begin
                clear_next = 1'b0;
            end
        end
    end

    // control state
    logic busy_reg;
    logic busy_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic accept;
    logic fire;

    assign s_tready = !busy_reg && !clear_reg;
    assign accept   = s_tvalid && s_tready;
    assign fire     = busy_reg && (!m_valid_reg || m_tready);

    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (fire) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            busy_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            clear_reg     <= clear_next;
            clear_cnt_reg <= clear_cnt_next;
            busy_reg      <= busy_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // command held while the slot is read and updated
    logic [bct_pkg::CMD_W-1:0]  cmd_reg;
    logic [bct_pkg::WORD_W-1:0] gen_reg;
    bct_pkg::words_t            words_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic                       in_range_reg;
    logic [ADDR_W-1:0]          in_addr;
    logic                       in_range;

    assign in_addr  = ADDR_W'(in_index);
    assign in_range = ({1'b0, in_index} < body_count_reg) &&
                      (32'(in_index) < 32'(NUM_BODIES));

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= in_command;
            gen_reg      <= in_generation;
            words_reg    <= in_words;
            addr_reg     <= in_addr;
            in_range_reg <= in_range;
        end
    end

    // record store
    bct_pkg::body_rec_t rd_rec;
    bct_pkg::body_rec_t new_rec;
    bct_pkg::body_rec_t wr_rec;
    logic               exec_ok;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;

    assign wr_en   = clear_reg || (fire && in_range_reg && exec_ok);
    assign wr_addr = clear_reg ? clear_cnt_reg : addr_reg;
    assign wr_rec  = clear_reg ? '0 : new_rec;

    bct_mem #(
        .NUM_BODIES (NUM_BODIES),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_rec),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec)
    );

    bct_exec u_exec (
        .command     (cmd_reg),
        .generation  (gen_reg),
        .words       (words_reg),
        .sector_half (sector_half_reg),
        .rec_in      (rd_rec),
        .ok          (exec_ok),
        .rec_out     (new_rec)
    );

    // result register
    logic                        res_ok_reg;
    logic [bct_pkg::WORD_W-1:0]  res_gen_reg;
    logic [bct_pkg::FLAGS_W-1:0] res_flags_reg;

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_ok_reg    <= in_range_reg && exec_ok;
            res_gen_reg   <= in_range_reg ? new_rec.generation : '0;
            res_flags_reg <= in_range_reg ? new_rec.flags : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, res_flags_reg, res_gen_reg, res_ok_reg};

endmodule
`default_nettype wire

// ----- rtl/core/bct_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bct_mem
// Body record store: one synchronous memory, one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module bct_mem #(
    parameter int NUM_BODIES = bct_pkg::NUM_BODIES_DEF,
    parameter int ADDR_W     = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output bct_pkg::body_rec_t     rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire bct_pkg::body_rec_t wr_data
);

    bct_pkg::body_rec_t mem [NUM_BODIES];
    bct_pkg::body_rec_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/bct_exec.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bct_exec
// Command execution: checks one command against the slot record read from
// the store and forms the updated record and the accept flag.
// ----------------------------------------------------------------------------
module bct_exec (
    input  wire logic [bct_pkg::CMD_W-1:0]         command,
    input  wire logic [bct_pkg::WORD_W-1:0]        generation,
    input  wire bct_pkg::words_t                   words,
    input  wire logic [bct_pkg::SECTOR_HALF_W-1:0] sector_half,
    input  wire bct_pkg::body_rec_t                rec_in,
    output logic                                   ok,
    output bct_pkg::body_rec_t                     rec_out
);

    logic alive;
    logic gen_match;
    logic spawn_gen_ok;
    logic spawn_payload_ok;
    logic [bct_pkg::WORD_W-1:0] spawn_flags;
    logic [bct_pkg::WORD_W-1:0] inv_mass;
    logic [bct_pkg::WORD_W-1:0] radius;
    logic is_static;
    logic inv_ok;
    logic pos_ok;

    assign alive     = rec_in.flags[bct_pkg::FLAG_ALIVE];
    assign gen_match = (rec_in.generation == generation);

    // spawn checks on generation and payload
    assign spawn_flags = words[11];
    assign inv_mass    = words[7];
    assign radius      = words[3];
    assign is_static   = spawn_flags[bct_pkg::FLAG_STATIC];
    assign spawn_gen_ok = (generation != bct_pkg::GEN_MAX) && !alive &&
        (gen_match || ((rec_in.generation != bct_pkg::GEN_MAX) &&
                       (rec_in.generation + 32'd1 == generation)));
    assign pos_ok = bct_pkg::in_sector(words[4], sector_half) &&
                    bct_pkg::in_sector(words[5], sector_half) &&
                    bct_pkg::in_sector(words[6], sector_half);
    assign inv_ok = !inv_mass[bct_pkg::WORD_W-1] &&
                    (is_static ? (inv_mass == '0) : (inv_mass != '0));
    assign spawn_payload_ok = spawn_flags[bct_pkg::FLAG_ALIVE] &&
                              (spawn_flags[bct_pkg::WORD_W-1:bct_pkg::FLAGS_W] == '0) &&
                              !radius[bct_pkg::WORD_W-1] && (radius != '0) &&
                              pos_ok && inv_ok;

    // per-command update
    always_comb begin
        ok      = 1'b0;
        rec_out = rec_in;
        case (command)
            bct_pkg::CMD_SPAWN: begin
                if (spawn_gen_ok && spawn_payload_ok) begin
                    ok                 = 1'b1;
                    rec_out.generation = generation;
                    rec_out.flags      = spawn_flags[bct_pkg::FLAGS_W-1:0];
                    rec_out.sector_x   = words[0];
                    rec_out.sector_y   = words[1];
                    rec_out.sector_z   = words[2];
                    rec_out.radius     = words[3];
                    rec_out.position_x = words[4];
                    rec_out.position_y = words[5];
                    rec_out.position_z = words[6];
                    rec_out.inv_mass   = words[7];
                    rec_out.velocity_x = words[8];
                    rec_out.velocity_y = words[9];
                    rec_out.velocity_z = words[10];
                end
            end
            bct_pkg::CMD_DESTROY: begin
                if (alive && gen_match) begin
                    ok                 = 1'b1;
                    rec_out            = '0;
                    rec_out.generation = (generation == bct_pkg::GEN_MAX) ?
                                         generation : generation + 32'd1;
                end
            end
            bct_pkg::CMD_CORRECTION: begin
                if (alive && gen_match) begin
                    ok                 = 1'b1;
                    rec_out.sector_x   = words[0];
                    rec_out.sector_y   = words[1];
                    rec_out.sector_z   = words[2];
                    rec_out.position_x = words[4];
                    rec_out.position_y = words[5];
                    rec_out.position_z = words[6];
                    rec_out.velocity_x = words[8];
                    rec_out.velocity_y = words[9];
                    rec_out.velocity_z = words[10];
                end
            end
            bct_pkg::CMD_SET_VEL: begin
                if (alive && gen_match) begin
                    ok                 = 1'b1;
                    rec_out.velocity_x = words[0];
                    rec_out.velocity_y = words[1];
                    rec_out.velocity_z = words[2];
                end
            end
            bct_pkg::CMD_IMPULSE: begin
                if (alive && gen_match) begin
                    ok                 = 1'b1;
                    rec_out.velocity_x = bct_pkg::sat_add(rec_in.velocity_x, words[0]);
                    rec_out.velocity_y = bct_pkg::sat_add(rec_in.velocity_y, words[1]);
                    rec_out.velocity_z = bct_pkg::sat_add(rec_in.velocity_z, words[2]);
                end
            end
            bct_pkg::CMD_SET_AWAKE: begin
                if (alive && gen_match) begin
                    ok = 1'b1;
                    rec_out.flags[bct_pkg::FLAG_AWAKE] = (words[0] != '0);
                end
            end
            default: begin
                ok      = 1'b0;
                rec_out = rec_in;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- tb/body_command_table_checker.sv -----
// ----------------------------------------------------------------------------
// body_command_table_checker
// Watches the command, result and configuration ports of the body command
// table, predicts the status of every command beat and compares each result
// beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module body_command_table_checker #(
    parameter int NUM_BODIES = bct_pkg::NUM_BODIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [bct_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [bct_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    // command, body_index, generation, payload_01 .. payload_ab, zero pad
    input  wire logic [431:0]                      s_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // accepted, slot_generation, slot_flags, zero pad
    input  wire logic [39:0]                       m_tdata,
    output int                                     failures,
    output int                                     results_pending
);
    import bct_pkg::*;

    typedef struct packed {
        logic               accepted;
        logic [WORD_W-1:0]  generation;
        logic [FLAGS_W-1:0] flags;
    } slot_status_t;

    // only generation and flags ever reach a result beat, so the rest of
    // the body record is not kept here
    logic [WORD_W-1:0]        gen_store  [NUM_BODIES];
    logic [FLAGS_W-1:0]       flag_store [NUM_BODIES];
    logic [BODY_COUNT_W-1:0]  count_reg;
    logic [SECTOR_HALF_W-1:0] half_reg;
    slot_status_t             status_q [$];
    int                       fail_total = 0;

    function automatic longint signed_word(input logic [WORD_W-1:0] x);
        return longint'($signed(x));
    endfunction

    // spawn payload: flags, radius, position inside sector, inverse mass
    function automatic logic spawn_payload_ok(input words_t w);
        longint half;
        longint inv;
        logic   all_in;
        int     k;
        half   = longint'(half_reg);
        all_in = 1'b1;
        for (k = 4; k <= 6; k++) begin
            if (signed_word(w[k]) < -half || signed_word(w[k]) >= half)
                all_in = 1'b0;
        end
        inv = signed_word(w[7]);
        return w[11][FLAG_ALIVE] && (w[11][WORD_W-1:FLAGS_W] == '0) &&
               (signed_word(w[3]) > 0) && all_in && (inv >= 0) &&
               (w[11][FLAG_STATIC] ? (inv == 0) : (inv != 0));
    endfunction

    // applies one command to the slot copy and returns the slot status
    function automatic slot_status_t apply_body_command(input logic [CMD_W-1:0]   cmd,
                                                        input logic [INDEX_W-1:0] idx,
                                                        input logic [WORD_W-1:0]  gen,
                                                        input words_t             w);
        slot_status_t      st;
        logic [WORD_W-1:0] stored;
        logic              alive;
        logic              ok;
        int                slots_in_use;
        slots_in_use = (int'(count_reg) < NUM_BODIES) ? int'(count_reg) : NUM_BODIES;
        st = '0;
        if (int'(idx) >= slots_in_use)
            return st;
        stored = gen_store[idx];
        alive  = flag_store[idx][FLAG_ALIVE];
        ok     = 1'b0;
        if (cmd == CMD_SPAWN) begin
            ok = !alive && (gen != GEN_MAX) &&
                 ((gen == stored) || ((stored != GEN_MAX) && (gen == stored + 1'b1))) &&
                 spawn_payload_ok(w);
            if (ok) begin
                gen_store[idx]  = gen;
                flag_store[idx] = w[11][FLAGS_W-1:0];
            end
        end else if (alive && (gen == stored)) begin
            ok = 1'b1;
            case (cmd)
                CMD_DESTROY: begin
                    flag_store[idx] = '0;
                    gen_store[idx]  = (gen == GEN_MAX) ? gen : gen + 1'b1;
                end
                CMD_SET_AWAKE: flag_store[idx][FLAG_AWAKE] = (w[0] != '0);
                CMD_CORRECTION, CMD_SET_VEL, CMD_IMPULSE: ;
                default: ok = 1'b0;
            endcase
        end
        st.accepted   = ok;
        st.generation = gen_store[idx];
        st.flags      = flag_store[idx];
        return st;
    endfunction

    always @(posedge aclk) begin : monitor
        slot_status_t got;
        slot_status_t want;
        slot_status_t pred;
        int           i;
        if (!aresetn) begin
            for (i = 0; i < NUM_BODIES; i++) begin
                gen_store[i]  = '0;
                flag_store[i] = '0;
            end
            count_reg = BODY_COUNT_RST;
            half_reg  = SECTOR_HALF_RST;
            status_q.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.accepted   = m_tdata[0];
                got.generation = m_tdata[32:1];
                got.flags      = m_tdata[35:33];
                if (status_q.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fail_total++;
                end else begin
                    want = status_q.pop_front();
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, actual %0d",
                               want.accepted, got.accepted);
                        fail_total++;
                    end
                    if (got.generation !== want.generation) begin
                        $error("slot_generation: expected %0h, actual %0h",
                               want.generation, got.generation);
                        fail_total++;
                    end
                    if (got.flags !== want.flags) begin
                        $error("slot_flags: expected %0h, actual %0h",
                               want.flags, got.flags);
                        fail_total++;
                    end
                end
            end
            // command beat
            if (s_tvalid && s_tready) begin
                pred = apply_body_command(s_tdata[2:0], s_tdata[12:3],
                                          s_tdata[44:13], s_tdata[428:45]);
                status_q = {status_q, pred};
            end
            // register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_BODY_COUNT:  count_reg = cfg_wdata[BODY_COUNT_W-1:0];
                    CFG_SECTOR_HALF: half_reg  = cfg_wdata[SECTOR_HALF_W-1:0];
                    default: ;
                endcase
            end
        end
        results_pending <= status_q.size();
        failures        <= fail_total;
    end

endmodule

// ----- tb/body_command_table_unit_tb.sv -----
// ----------------------------------------------------------------------------
// body_command_table_unit_tb
// Drives the body command table with a directed set of commands and then
// with random, mostly well-formed slot lifecycles under several register
// settings, with bursty input and a stalling result receiver. The checker
// beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module body_command_table_unit_tb;
    import bct_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 500_000;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

    typedef enum int {
        SPAWN_OK,
        SPAWN_NOT_ALIVE,
        SPAWN_HIGH_FLAGS,
        SPAWN_ZERO_RADIUS,
        SPAWN_NEG_RADIUS,
        SPAWN_OUTSIDE,
        SPAWN_NEG_INV_MASS,
        SPAWN_STATIC_MASS,
        SPAWN_MASSLESS
    } spawn_defect_e;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY_OPEN,
        SINK_MOSTLY_HELD
    } sink_mode_e;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [431:0]          s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    int                    fail_count;
    int                    results_pending;

    bit                       hold_results = 1'b0;
    int                       burst_left   = 0;
    logic [BODY_COUNT_W-1:0]  cur_count    = BODY_COUNT_RST;
    logic [SECTOR_HALF_W-1:0] cur_half     = SECTOR_HALF_RST;
    // what the stimulus believes about each slot, used to build sequences
    bit [WORD_W-1:0]          gen_hint   [NUM_BODIES_DEF];
    bit                       alive_hint [NUM_BODIES_DEF];

    body_command_table_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    body_command_table_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .failures        (fail_count),
        .results_pending (results_pending)
    );

    always #2 aclk = ~aclk;

    initial begin : run_limit
        #(4 * LIMIT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    // result receiver: random stall modes, plus one long hold on request
    initial begin : result_sink
        sink_mode_e mode;
        int         mode_left;
        int         hold_left;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_results && hold_left == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_results = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_e'($urandom_range(SINK_MOSTLY_HELD, SINK_OPEN));
                    mode_left = $urandom_range(64, 8);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:        m_tready <= 1'b1;
                    SINK_COIN:        m_tready <= 1'($urandom_range(1, 0));
                    SINK_MOSTLY_OPEN: m_tready <= ($urandom_range(7, 0) != 0);
                    default:          m_tready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    // one command beat, then the burst or gap that follows it
    task automatic send_beat(input logic [CMD_W-1:0]   cmd,
                             input logic [INDEX_W-1:0] idx,
                             input logic [WORD_W-1:0]  gen,
                             input words_t             w);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, w, gen, idx, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(10, 1);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 30)
                                                     : $urandom_range(12, 1);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [BODY_COUNT_W-1:0]  count,
                              input logic [SECTOR_HALF_W-1:0] half);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_BODY_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(negedge aclk);
        cfg_addr  <= CFG_SECTOR_HALF;
        cfg_wdata <= half;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_count = count;
        cur_half  = half;
    endtask

    // a position word inside or just outside the current sector
    function automatic logic [WORD_W-1:0] sector_coord(input bit inside_sector);
        longint h;
        longint p;
        h = longint'(cur_half);
        if (!inside_sector) begin
            p = ($urandom_range(1, 0) != 0) ? h : -h - 1;
        end else begin
            case ($urandom_range(3, 0))
                0:       p = -h;
                1:       p = h - 1;
                2:       p = 0;
                default: p = longint'($urandom_range(32'(2 * h - 1), 0)) - h;
            endcase
        end
        return p[WORD_W-1:0];
    endfunction

    // spawn payload, valid unless a defect is asked for
    function automatic words_t spawn_words(input logic [FLAGS_W-1:0] flags,
                                           input spawn_defect_e      defect);
        words_t w;
        int     k;
        int     axis;
        for (k = 0; k < NUM_WORDS; k++)
            w[k] = $urandom;
        axis = $urandom_range(6, 4);
        w[3] = $urandom_range(32'h7FFF_FFFF, 1);
        for (k = 4; k <= 6; k++)
            w[k] = sector_coord(1'b1);
        w[7]  = flags[FLAG_STATIC] ? '0 : WORD_W'($urandom_range(32'h7FFF_FFFF, 1));
        w[11] = WORD_W'(flags);
        case (defect)
            SPAWN_NOT_ALIVE:    w[11][FLAG_ALIVE] = 1'b0;
            SPAWN_HIGH_FLAGS:   w[11] = w[11] | (32'd1 << $urandom_range(31, 3));
            SPAWN_ZERO_RADIUS:  w[3] = '0;
            SPAWN_NEG_RADIUS:   w[3][WORD_W-1] = 1'b1;
            SPAWN_OUTSIDE:      w[axis] = sector_coord(1'b0);
            SPAWN_NEG_INV_MASS: w[7][WORD_W-1] = 1'b1;
            SPAWN_STATIC_MASS: begin
                w[11][FLAG_STATIC] = 1'b1;
                w[7] = $urandom_range(32'h7FFF_FFFF, 1);
            end
            SPAWN_MASSLESS: begin
                w[11][FLAG_STATIC] = 1'b0;
                w[7] = '0;
            end
            default: ;
        endcase
        return w;
    endfunction

    // mostly well-formed slot lifecycles, some noise
    task automatic send_random_command();
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] idx;
        logic [WORD_W-1:0]  gen;
        logic [WORD_W-1:0]  g;
        words_t             w;
        bit                 good;
        int                 r;
        int                 k;
        int                 pool;
        pool = (cur_count < 22) ? int'(cur_count) + 2 : 24;
        good = 1'b0;
        for (k = 0; k < NUM_WORDS; k++)
            w[k] = $urandom;
        if ($urandom_range(99, 0) < 15) begin
            cmd = CMD_W'($urandom_range(7, 0));
            idx = INDEX_W'($urandom);
            gen = ($urandom_range(1, 0) != 0) ? gen_hint[idx] : WORD_W'($urandom);
        end else begin
            idx = ($urandom_range(9, 0) == 0) ? INDEX_W'($urandom)
                                              : INDEX_W'($urandom_range(pool - 1, 0));
            g   = gen_hint[idx];
            gen = g;
            r   = $urandom_range(99, 0);
            if (!alive_hint[idx]) begin
                cmd = CMD_SPAWN;
                if (g != GEN_MAX && $urandom_range(1, 0) != 0)
                    gen = g + 1'b1;
                if (r < 75) begin
                    good = 1'b1;
                    w = spawn_words({2'($urandom_range(3, 0)), 1'b1}, SPAWN_OK);
                end else if (r < 80) begin
                    gen = g + 2'd2;
                    w = spawn_words({2'($urandom_range(3, 0)), 1'b1}, SPAWN_OK);
                end else begin
                    w = spawn_words({2'($urandom_range(3, 0)), 1'b1},
                                    spawn_defect_e'($urandom_range(SPAWN_MASSLESS,
                                                                   SPAWN_NOT_ALIVE)));
                    if (r >= 95)
                        cmd = CMD_W'($urandom_range(CMD_SET_AWAKE, CMD_CORRECTION));
                end
            end else begin
                if (r < 12) begin
                    cmd = CMD_DESTROY;
                end else if (r < 18) begin
                    cmd = CMD_SPAWN;
                    w = spawn_words({2'($urandom_range(3, 0)), 1'b1}, SPAWN_OK);
                end else if (r < 38) begin
                    cmd = CMD_CORRECTION;
                end else if (r < 53) begin
                    cmd = CMD_SET_VEL;
                end else if (r < 70) begin
                    cmd = CMD_IMPULSE;
                end else if (r < 88) begin
                    cmd = CMD_SET_AWAKE;
                    if ($urandom_range(1, 0) != 0)
                        w[0] = '0;
                end else begin
                    cmd = CMD_W'($urandom_range(7, 0));
                    gen = g ^ (32'd1 << $urandom_range(31, 0));
                end
            end
        end
        send_beat(cmd, idx, gen, w);
        // follow the slot lifecycle
        if (idx < cur_count) begin
            if (cmd == CMD_DESTROY && alive_hint[idx] && gen == gen_hint[idx]) begin
                alive_hint[idx] = 1'b0;
                gen_hint[idx]   = (gen == GEN_MAX) ? gen : gen + 1'b1;
            end else if (cmd == CMD_SPAWN && good && !alive_hint[idx] && gen != GEN_MAX) begin
                alive_hint[idx] = 1'b1;
                gen_hint[idx]   = gen;
            end
        end
    endtask

    task automatic run_random(input int n, input int hold_at, input int pause_at);
        int i;
        for (i = 0; i < n; i++) begin
            if (i == hold_at)
                hold_results = 1'b1;
            if (i == pause_at)
                wait_drained();
            send_random_command();
        end
    endtask

    initial begin : stimulus
        words_t                   w;
        int                       d;
        int                       p;
        int                       phase_items [6] = '{300, 300, 150, 40, 300, 300};
        logic [BODY_COUNT_W-1:0]  phase_count [6] = '{11'd1024, 11'd20, 11'd1, 11'd0,
                                                      11'd1024, 11'd700};
        logic [SECTOR_HALF_W-1:0] phase_half  [6] = '{31'h4000_0000, 31'h7FFF_FFFF,
                                                      31'd1, 31'd5000, 31'd1000,
                                                      31'h0010_0000};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_config(11'd1024, 31'd100);

        // valid spawn at the sector corners, then a rejected respawn
        w = spawn_words(3'b001, SPAWN_OK);
        w[3] = 32'd1;
        w[4] = -32'd100;
        w[5] = 32'd99;
        w[6] = '0;
        w[7] = 32'd1;
        send_beat(CMD_SPAWN, 10'd5, 32'd0, w);
        send_beat(CMD_SPAWN, 10'd5, 32'd0, w);
        // updates on a live slot, impulse at positive saturation
        w = '1;
        send_beat(CMD_CORRECTION, 10'd5, 32'd0, w);
        w[0] = 32'h7FFF_FFFF;
        w[1] = 32'h7FFF_FFFF;
        w[2] = 32'h7FFF_FFFF;
        send_beat(CMD_SET_VEL, 10'd5, 32'd0, w);
        send_beat(CMD_IMPULSE, 10'd5, 32'd0, w);
        send_beat(CMD_SET_AWAKE, 10'd5, 32'd0, w);
        w[0] = '0;
        send_beat(CMD_SET_AWAKE, 10'd5, 32'd0, w);
        // wrong generation, then destroy
        send_beat(CMD_CORRECTION, 10'd5, 32'd1, w);
        send_beat(CMD_DESTROY, 10'd5, 32'd0, w);
        // stale generation rejected, next generation accepted as static body
        w = spawn_words(3'b001, SPAWN_OK);
        send_beat(CMD_SPAWN, 10'd5, 32'd0, w);
        w = spawn_words(3'b101, SPAWN_OK);
        send_beat(CMD_SPAWN, 10'd5, 32'd2, w);
        // spawn with the maximum generation
        w = spawn_words(3'b001, SPAWN_OK);
        send_beat(CMD_SPAWN, 10'd6, GEN_MAX, w);
        // every payload defect on a fresh slot
        for (d = SPAWN_NOT_ALIVE; d <= SPAWN_MASSLESS; d++)
            send_beat(CMD_SPAWN, 10'd6, 32'd0, spawn_words(3'b001, spawn_defect_e'(d)));
        // unknown commands on a live slot
        send_beat(CMD_RESERVED_LO, 10'd5, 32'd2, w);
        send_beat(CMD_RESERVED_HI, 10'd5, 32'd2, w);
        // last slot, all flags set
        send_beat(CMD_SPAWN, 10'd1023, 32'd1, spawn_words(3'b111, SPAWN_OK));
        // all-ones beat
        w = '1;
        send_beat(CMD_RESERVED_HI, 10'd1023, GEN_MAX, w);
        wait_drained();
        gen_hint[5]      = 32'd2;
        alive_hint[5]    = 1'b1;
        gen_hint[1023]   = 32'd1;
        alive_hint[1023] = 1'b1;

        // random phases over several register settings
        for (p = 0; p < 6; p++) begin
            set_config(phase_count[p], phase_half[p]);
            run_random(phase_items[p], (p == 0) ? 100 : -1, (p == 4) ? 150 : -1);
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
